// ===== hw/rtl/pfr_pkg.sv =====
// constants, frame layout and verdict codes for the packet frame receiver
// no dependencies; imported by packet_frame_receiver
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int unsigned PAYLOAD_MAX = 1024;
  localparam int unsigned BUF_BYTES   = 9 + PAYLOAD_MAX;
  localparam int unsigned CNT_W       = $clog2(BUF_BYTES + 1);
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned PLEN_W      = 11;

  localparam logic [7:0] MAGIC_FIRST  = 8'hAA;
  localparam logic [7:0] MAGIC_SECOND = 8'hBB;
  localparam logic [7:0] KIND_ACK     = 8'hA0;
  localparam logic [7:0] KIND_NACK    = 8'hA1;

  // byte positions within the frame header, minimum frame length and counter saturation
  localparam logic [CNT_W-1:0] POS_MAGIC0  = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_MAGIC1  = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_TYPE    = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_LEN_LO  = CNT_W'(6);
  localparam logic [CNT_W-1:0] POS_LEN_HI  = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_PAYLOAD = CNT_W'(8);
  localparam logic [CNT_W-1:0] MIN_FRAME   = CNT_W'(9);
  localparam logic [CNT_W-1:0] CNT_SAT     = CNT_W'(BUF_BYTES);

  localparam logic [LEN_W:0]   OVERHEAD    = (LEN_W + 1)'(9);
  localparam logic [LEN_W-1:0] LEN_LIMIT   = LEN_W'(PAYLOAD_MAX);

  typedef enum logic [1:0] {
    VerdictAck    = 2'd0,
    VerdictNack   = 2'd1,
    VerdictReject = 2'd2
  } verdict_e;

endpackage

// ===== hw/rtl/packet_frame_receiver.sv =====
// packet frame receiver: header capture, checksum and verdict per chunk
// depends on pfr_pkg
`timescale 1ns / 1ps

// Takes one received byte per transaction, with chunk_end_i marking the last
// byte of a chunk, and delivers one verdict transaction per chunk: ACK, NACK or
// reject, with the frame type and (for ACK/NACK) the payload length. For
// each byte the frame state registers are updated and, on the last byte,
// the verdict is computed in the same cycle and loaded into a single output
// register, so a byte can be accepted every cycle. Input is stalled only while
// that output register holds a verdict that is not being taken. No clearing
// pass after reset: the block is ready on the first cycle.
module packet_frame_receiver
  import pfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                chunk_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          verdict_o,
  output logic [7:0]          frame_type_o,
  output logic [PLEN_W-1:0]   payload_length_o
);

  logic [CNT_W-1:0]  byte_count_q, byte_count_d;
  logic              magic_good_q, magic_good_d;
  logic [7:0]        type_hold_q, type_hold_d;
  logic [LEN_W-1:0]  length_hold_q, length_hold_d;
  logic [7:0]        xor_running_q, xor_running_d;
  logic              overrun_q, overrun_d;

  logic              out_valid_q;
  verdict_e          verdict_q, verdict_d;
  logic [7:0]        ftype_q;
  logic [PLEN_W-1:0] plen_q, plen_d;

  logic              in_fire, out_fire, frame_ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // per-byte state update
  always_comb begin
    byte_count_d  = byte_count_q;
    magic_good_d  = magic_good_q;
    type_hold_d   = type_hold_q;
    length_hold_d = length_hold_q;
    xor_running_d = xor_running_q;
    overrun_d     = overrun_q;
    if (byte_count_q >= CNT_SAT) begin
      overrun_d = 1'b1;
    end else begin
      if (byte_count_q == POS_MAGIC0 && rx_byte_i != MAGIC_FIRST)  magic_good_d = 1'b0;
      if (byte_count_q == POS_MAGIC1 && rx_byte_i != MAGIC_SECOND) magic_good_d = 1'b0;
      if (byte_count_q == POS_TYPE)   type_hold_d = rx_byte_i;
      if (byte_count_q == POS_LEN_LO) length_hold_d[7:0]  = rx_byte_i;
      if (byte_count_q == POS_LEN_HI) length_hold_d[15:8] = rx_byte_i;
      if (byte_count_q >= POS_PAYLOAD) xor_running_d = xor_running_q ^ rx_byte_i;
      byte_count_d = byte_count_q + CNT_W'(1);
    end
  end

  // verdict from the state including this byte
  always_comb begin
    frame_ok = !overrun_d
            && (byte_count_d >= MIN_FRAME)
            && magic_good_d
            && (length_hold_d <= LEN_LIMIT)
            && ((LEN_W + 1)'(byte_count_d) == ((LEN_W + 1)'(length_hold_d) + OVERHEAD))
            && (xor_running_d == 8'h00);
    verdict_d = VerdictReject;
    plen_d    = '0;
    if (frame_ok && type_hold_d == KIND_ACK) begin
      verdict_d = VerdictAck;
    end else if (frame_ok && type_hold_d == KIND_NACK) begin
      verdict_d = VerdictNack;
    end
    if (verdict_d != VerdictReject) plen_d = PLEN_W'(length_hold_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      magic_good_q  <= 1'b1;
      type_hold_q   <= '0;
      length_hold_q <= '0;
      xor_running_q <= '0;
      overrun_q     <= 1'b0;
    end else if (in_fire) begin
      if (chunk_end_i) begin
        // chunk closed: back to the start-of-frame state
        byte_count_q  <= '0;
        magic_good_q  <= 1'b1;
        type_hold_q   <= '0;
        length_hold_q <= '0;
        xor_running_q <= '0;
        overrun_q     <= 1'b0;
      end else begin
        byte_count_q  <= byte_count_d;
        magic_good_q  <= magic_good_d;
        type_hold_q   <= type_hold_d;
        length_hold_q <= length_hold_d;
        xor_running_q <= xor_running_d;
        overrun_q     <= overrun_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && chunk_end_i) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && chunk_end_i) begin
      verdict_q <= verdict_d;
      ftype_q   <= type_hold_d;
      plen_q    <= plen_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign frame_type_o     = ftype_q;
  assign payload_length_o = plen_q;

  // no byte taken while a verdict is stuck in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_fire)
    else $error("byte accepted while output register blocked");

  // the byte counter never runs past the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CNT_SAT)
    else $error("byte count beyond saturation");

  // closing a chunk returns the frame state to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && chunk_end_i) |=> (byte_count_q == '0 && magic_good_q && !overrun_q))
    else $error("frame state not cleared after chunk end");

  // a rejected frame never reports a payload length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && verdict_q == VerdictReject) |-> (plen_q == '0))
    else $error("payload length on rejected frame");

  // a counted byte below saturation that does not close the chunk moves the counter by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !chunk_end_i && byte_count_q < CNT_SAT)
      |=> (byte_count_q == $past(byte_count_q) + CNT_W'(1)))
    else $error("byte count did not advance");

endmodule
